// ===== hw/rtl/pbrf_pkg.sv =====
// Package for the pixel blank range fixer: payload structs, codes, constants
// and the binary64 compare helpers. No dependencies.
package pbrf_pkg;

  localparam int RANGE_SLOTS = 8;
  localparam int SLOT_BITS   = 3;
  localparam int COUNT_BITS  = 32;
  localparam int TOTAL_BITS  = 32;

  localparam logic [63:0] ALL_ONES_NAN = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [1:0] {
    CMD_PIXEL = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_REPLACE_ENABLE = 2'd0,
    REG_REPLACE_VALUE  = 2'd1,
    REG_RANGES_IN_USE  = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] pixel_bits;
    logic [2:0]  entry_index;
    logic [63:0] bound_low;
    logic [63:0] bound_high;
    logic        upper_only;
    logic        lower_only;
  } in_item_t;

  typedef struct packed {
    logic [63:0] pixel_out;
    logic        range_hit;
    logic        was_fixed;
    logic [31:0] hit_total;
    logic [31:0] fixed_total;
  } out_item_t;

  typedef struct packed {
    logic [63:0] low;
    logic [63:0] high;
    logic        upper_only;
    logic        lower_only;
  } range_entry_t;

  // IEEE test: true for any NaN pattern.
  function automatic logic is_nan(input logic [63:0] a);
    return (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
  endfunction

  // a <= b under IEEE rules (false if either is NaN, +0 == -0).
  function automatic logic fp_le(input logic [63:0] a, input logic [63:0] b);
    logic both_zero;
    logic res;
    both_zero = (a[62:0] == 63'd0) && (b[62:0] == 63'd0);
    if (is_nan(a) || is_nan(b)) res = 1'b0;
    else if (both_zero) res = 1'b1;
    else if (a[63] != b[63]) res = a[63];
    else if (!a[63]) res = (a[62:0] <= b[62:0]);
    else res = (a[62:0] >= b[62:0]);
    return res;
  endfunction

endpackage

// ===== hw/rtl/pbrf_match.sv =====
// Parallel range test of one pixel against the range table.
// Depends on pbrf_pkg.
module pbrf_match (
  input  logic [63:0]                    pixel,
  input  pbrf_pkg::range_entry_t         entries [pbrf_pkg::RANGE_SLOTS],
  input  logic [3:0]                     ranges_in_use,
  output logic                           hit
);
  logic [pbrf_pkg::RANGE_SLOTS-1:0] slot_hit;

  always_comb begin
    for (int k = 0; k < pbrf_pkg::RANGE_SLOTS; k++) begin
      slot_hit[k] = (5'(k) < {1'b0, ranges_in_use}) && (
        (entries[k].upper_only && pbrf_pkg::fp_le(pixel, entries[k].high)) ||
        (entries[k].lower_only && pbrf_pkg::fp_le(entries[k].low, pixel)) ||
        (pbrf_pkg::fp_le(entries[k].low, pixel) &&
         pbrf_pkg::fp_le(pixel, entries[k].high)));
    end
  end

  assign hit = |slot_hit;
endmodule

// ===== hw/rtl/pixel_blank_range_fixer.sv =====
// Top level of the pixel blank range fixer: input register, range table,
// counters and result register. Depends on pbrf_pkg and pbrf_match.
//
// Usage:
//  - in channel (in_valid/in_ready/in_data): one item per cycle while in_ready
//    is high; cmd selects pixel, range load or counter clear.
//  - out channel (out_valid/out_ready/out_data): exactly one result item
//    per input item, in order.
//  - cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): register writes,
//    always ready; write only while the block is idle.
//  - Path: an accepted item passes the input register, then the result
//    register, before it shows at out. Throughput: one item per cycle while
//    out is drained, set by the combinational compare and counter stage.
//  - Stall: when out_ready is low the result register holds; the input
//    register still takes one item if empty, then in_ready drops.
//  - Reset: sync, active high; clears valid flags, counters and config
//    registers. The range table is not cleared and must be loaded before
//    ranges_in_use covers a slot.
module pixel_blank_range_fixer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pbrf_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pbrf_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [63:0]          cfg_data
);
  // config registers
  logic        replace_enable;
  logic [63:0] replace_value;
  logic [3:0]  ranges_in_use;

  // stage 1: input register
  logic                stage_valid;
  pbrf_pkg::in_item_t  stage;
  logic                stage_go;

  pbrf_pkg::range_entry_t entries [pbrf_pkg::RANGE_SLOTS];
  logic [pbrf_pkg::COUNT_BITS-1:0] hit_counter, hit_counter_next;
  logic [pbrf_pkg::COUNT_BITS-1:0] fixed_counter, fixed_counter_next;
  pbrf_pkg::out_item_t result_next;
  logic in_hit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      replace_enable <= 1'b0;
      replace_value  <= '0;
      ranges_in_use  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pbrf_pkg::REG_REPLACE_ENABLE: replace_enable <= cfg_data[0];
        pbrf_pkg::REG_REPLACE_VALUE:  replace_value  <= cfg_data;
        pbrf_pkg::REG_RANGES_IN_USE:  ranges_in_use  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // stage 1 advances when the result register is empty or being drained
  assign stage_go = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || stage_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage <= in_data;
    end
  end

  pbrf_match u_match (
    .pixel         (stage.pixel_bits),
    .entries       (entries),
    .ranges_in_use (ranges_in_use),
    .hit           (in_hit)
  );

  // decision and counter update for the item in stage 1
  always_comb begin
    logic nan_fix;
    nan_fix = replace_enable && pbrf_pkg::is_nan(stage.pixel_bits);
    hit_counter_next   = hit_counter;
    fixed_counter_next = fixed_counter;
    result_next        = '0;
    unique case (pbrf_pkg::cmd_t'(stage.cmd))
      pbrf_pkg::CMD_PIXEL: begin
        if (nan_fix) begin
          result_next.pixel_out = replace_value;
          result_next.was_fixed = 1'b1;
        end else if (in_hit) begin
          result_next.range_hit = 1'b1;
          result_next.was_fixed = 1'b1;
          result_next.pixel_out = replace_enable ? replace_value
                                                 : pbrf_pkg::ALL_ONES_NAN;
        end else begin
          result_next.pixel_out = stage.pixel_bits;
        end
        if (result_next.range_hit && hit_counter != pbrf_pkg::COUNT_MAX)
          hit_counter_next = hit_counter + 1'b1;
        if (result_next.was_fixed && fixed_counter != pbrf_pkg::COUNT_MAX)
          fixed_counter_next = fixed_counter + 1'b1;
      end
      pbrf_pkg::CMD_CLEAR: begin
        hit_counter_next   = '0;
        fixed_counter_next = '0;
      end
      pbrf_pkg::CMD_LOAD, pbrf_pkg::CMD_NONE: ;
      default: ;
    endcase
    result_next.hit_total   = hit_counter_next[pbrf_pkg::TOTAL_BITS-1:0];
    result_next.fixed_total = fixed_counter_next[pbrf_pkg::TOTAL_BITS-1:0];
  end

  // range table: loaded when a load item leaves stage 1
  always_ff @(posedge clk) begin
    if (stage_go && stage.cmd == pbrf_pkg::CMD_LOAD) begin
      entries[stage.entry_index] <= '{low: stage.bound_low,
                                      high: stage.bound_high,
                                      upper_only: stage.upper_only,
                                      lower_only: stage.lower_only};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_counter   <= '0;
      fixed_counter <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (stage_go) begin
        hit_counter   <= hit_counter_next;
        fixed_counter <= fixed_counter_next;
      end
      if (stage_go) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_go) begin
      out_data <= result_next;
    end
  end

  // a stalled result must not be overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result overwritten while stalled");

  // fixed count never falls behind hit count within one item
  a_hit_implies_fixed: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_data.range_hit || out_data.was_fixed))
    else $error("range hit without fix");

  // a clear item leaves both totals at zero
  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    stage_go && stage.cmd == pbrf_pkg::CMD_CLEAR |=>
      hit_counter == '0 && fixed_counter == '0)
    else $error("clear did not zero counters");
endmodule
